// ===== hw/rtl/msi_pkg.sv =====
`default_nettype none
package msi_pkg;

  localparam int unsigned VALUE_W      = 31;
  localparam int unsigned CAPACITY_DEF = 64;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sorted_value;
    logic               final_res;
    logic               overflow;
  } out_word_t;

  typedef enum logic {
    WR_VALUE = 1'b0,
    WR_SHIFT = 1'b1
  } wr_sel_e;

  typedef struct packed {
    logic    latch_item;
    logic    dec_pos;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    rd_en;
    logic    emit;
    logic    inc_count;
    logic    set_drop;
    logic    clr_run;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic pos_zero;
    logic pos_one;
    logic greater;
    logic last;
    logic rd_last;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/merge_insertion_sorter.sv =====
`default_nettype none
// Sorts a run of 31-bit values. A word is taken when start is high and busy is
// low; each insertion walks the stored run down from the top through a simple
// dual-port RAM with one write and one read port. An empty store writes the
// word at once; otherwise each stored value greater than it moves up one slot
// before the word is placed. A full store drops the word and flags overflow.
// After the word marked last, the run streams out in ascending order, one
// result per cycle on strobe_o; the receiver cannot stall, so every strobe is
// taken as given. final_res marks the largest value.
module merge_insertion_sorter #(
  parameter int unsigned Capacity = msi_pkg::CAPACITY_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire msi_pkg::in_word_t in_word_i,
  output logic                   busy,
  output logic                   strobe_o,
  output msi_pkg::out_word_t     out_word_o
);
  import msi_pkg::*;

  cmd_t    cmd;
  status_t status;

  msi_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  msi_dpath #(
    .Capacity (Capacity)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .strobe_o   (strobe_o),
    .out_word_o (out_word_o)
  );

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy)
    else $error("result while idle");

  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && out_word_o.final_res) |=> (!busy && !strobe_o))
    else $error("activity after final word");

  a_no_accept_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(strobe_o) |-> $past(busy))
    else $error("stream began without a run");

endmodule
`default_nettype wire

// ===== hw/rtl/msi_ram.sv =====
`default_nettype none
module msi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/msi_dpath.sv =====
`default_nettype none
module msi_dpath #(
  parameter int unsigned Capacity = msi_pkg::CAPACITY_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire msi_pkg::in_word_t  in_word_i,
  input  wire msi_pkg::cmd_t      cmd_i,
  output msi_pkg::status_t        status_o,
  output logic                    strobe_o,
  output msi_pkg::out_word_t      out_word_o
);
  import msi_pkg::*;

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW  = $clog2(Capacity + 1);

  logic [VALUE_W-1:0] value_q;
  logic               last_q;
  logic [CntW-1:0]    count_q, count_d;
  logic               dropped_q, dropped_d;
  logic [AddrW-1:0]   pos_q, pos_d;
  logic [AddrW-1:0]   rd_q, rd_d;
  logic               vld_q, fin_q;
  logic [AddrW-1:0]   raddr;
  logic [VALUE_W-1:0] wdata, rdata;
  logic [CntW-1:0]    count_m1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      value_q <= in_word_i.value;
      last_q  <= in_word_i.last;
    end
  end

  assign count_m1 = count_q - CntW'(1);

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.latch_item) begin
      pos_d = count_q[AddrW-1:0];
    end else if (cmd_i.dec_pos) begin
      pos_d = pos_q - AddrW'(1);
    end
    count_d   = count_q;
    dropped_d = dropped_q;
    rd_d      = rd_q;
    if (cmd_i.inc_count) count_d = count_q + CntW'(1);
    if (cmd_i.set_drop)  dropped_d = 1'b1;
    if (cmd_i.emit)      rd_d = rd_q + AddrW'(1);
    if (cmd_i.clr_run) begin
      count_d   = '0;
      dropped_d = 1'b0;
      rd_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      pos_q     <= '0;
      rd_q      <= '0;
      vld_q     <= 1'b0;
      fin_q     <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
      pos_q     <= pos_d;
      rd_q      <= rd_d;
      vld_q     <= cmd_i.emit;
      fin_q     <= cmd_i.emit & status_o.rd_last;
    end
  end

  assign raddr = cmd_i.emit ? rd_q : pos_d - AddrW'(1);
  assign wdata = (cmd_i.wr_sel == WR_SHIFT) ? rdata : value_q;

  msi_ram #(
    .Width (VALUE_W),
    .Depth (Capacity)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (pos_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign status_o.full     = (count_q == CntW'(Capacity));
  assign status_o.pos_zero = (pos_q == '0);
  assign status_o.pos_one  = (pos_q == AddrW'(1));
  assign status_o.greater  = (rdata > value_q);
  assign status_o.last     = last_q;
  assign status_o.rd_last  = (CntW'(rd_q) == count_m1);

  assign strobe_o                = vld_q;
  assign out_word_o.sorted_value = rdata;
  assign out_word_o.final_res    = fin_q;
  assign out_word_o.overflow     = dropped_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("held count beyond capacity");

  a_no_insert_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |-> !cmd_i.inc_count)
    else $error("insert into full store");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && fin_q) |=> (count_q == '0 && !dropped_q))
    else $error("run not cleared after final word");

endmodule
`default_nettype wire

// ===== hw/rtl/msi_ctrl.sv =====
`default_nettype none
module msi_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire msi_pkg::status_t status_i,
  output msi_pkg::cmd_t         cmd_o,
  output logic                  busy_o
);
  import msi_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_SHIFT = 6'b000100,
    ST_PLACE = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_e;

  state_e state_q, state_d;
  state_e after_ins;

  assign after_ins = status_i.last ? ST_EMIT : ST_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.wr_sel = WR_VALUE;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.latch_item = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.full) begin
          cmd_o.set_drop = 1'b1;
          state_d = after_ins;
        end else if (status_i.pos_zero) begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.inc_count = 1'b1;
          state_d = after_ins;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd_o.wr_en = 1'b1;
        if (status_i.greater) begin
          cmd_o.wr_sel  = WR_SHIFT;
          cmd_o.dec_pos = 1'b1;
          if (status_i.pos_one) begin
            state_d = ST_PLACE;
          end else begin
            cmd_o.rd_en = 1'b1;
          end
        end else begin
          cmd_o.inc_count = 1'b1;
          state_d = after_ins;
        end
      end
      ST_PLACE: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.inc_count = 1'b1;
        state_d = after_ins;
      end
      ST_EMIT: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.emit  = 1'b1;
        if (status_i.rd_last) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd_o.clr_run = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  a_shift_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> !status_i.pos_zero)
    else $error("shift at slot zero");

  a_place_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PLACE) |-> status_i.pos_zero)
    else $error("place away from slot zero");

  a_emit_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> $past(state_q == ST_EMIT))
    else $error("flush without emit");

endmodule
`default_nettype wire
